/* src/vmt_pkg.sv */
// Package for the vertex matrix transform: payload structs, register map and
// mode codes. Used by every module under src; depends on nothing.
`timescale 1ns / 1ps
package vmt_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int NUM_REGS      = 8;
	localparam int ADDR_BITS     = 6;

	localparam logic [1:0] MODE_FULL    = 2'd0;
	localparam logic [1:0] MODE_ROT     = 2'd1;
	localparam logic [1:0] MODE_INV     = 2'd2;
	localparam logic [1:0] MODE_INV_ROT = 2'd3;

	localparam logic [63:0] RESET_LOW  = 64'd65536;
	localparam logic [63:0] RESET_HIGH = 64'd281474976710656;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} point_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               divide_fault;
		logic               overflow;
	} point_out_t;

	// Product and sum words are kept at 66 bits throughout the datapath.
	typedef logic signed [65:0] wide_t;

	// Per-stage control that travels with each transaction.
	typedef struct packed {
		logic       valid;
		logic [1:0] mode;
	} stage_ctl_t;
endpackage

/* src/vmt_regs.sv */
// Matrix register file behind the APB-style configuration port.
// Depends on vmt_pkg.
`timescale 1ns / 1ps
module vmt_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vmt_pkg::ADDR_BITS-1:0] paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic [63:0]                   regs [vmt_pkg::NUM_REGS]
);
	logic [63:0] regs_q [vmt_pkg::NUM_REGS];
	logic [2:0]  idx;

	assign idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[0] <= vmt_pkg::RESET_LOW;
			regs_q[1] <= '0;
			regs_q[2] <= vmt_pkg::RESET_HIGH;
			regs_q[3] <= '0;
			regs_q[4] <= '0;
			regs_q[5] <= vmt_pkg::RESET_LOW;
			regs_q[6] <= '0;
			regs_q[7] <= vmt_pkg::RESET_HIGH;
		end else if (psel && penable && pwrite) begin
			regs_q[idx] <= pwdata;
		end
	end

	assign prdata = regs_q[idx];
	assign regs   = regs_q;
endmodule

/* src/vmt_div.sv */
// Pipelined restoring divider: one quotient bit per stage, truncated toward zero,
// saturating magnitude. Depends on vmt_pkg.
`timescale 1ns / 1ps
module vmt_div #(
	parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF,
	parameter int QBITS     = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [63:0]         num_mag,
	input  logic [63:0]         den_mag,
	input  logic [3:0]          in_tag,
	output logic                out_valid,
	output logic [63:0]         quot,
	output logic [3:0]          out_tag
);
	// The numerator is scaled up by FRAC_BITS before the first stage. Its magnitude
	// stays below 2^(64-FRAC_BITS), so the scaled value fits the 64-bit word.
	logic [63:0] n_q [QBITS];
	logic [63:0] d_q [QBITS];
	logic [63:0] r_q [QBITS];
	logic [63:0] q_q [QBITS];
	logic        v_q [QBITS];
	logic [3:0]  t_q [QBITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QBITS; k++)
				v_q[k] <= 1'b0;
		end else begin
			v_q[0] <= in_valid;
			for (int k = 1; k < QBITS; k++)
				v_q[k] <= v_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] n_in;
		logic [63:0] d_in;
		logic [63:0] r_in;
		logic [63:0] q_in;
		logic [3:0]  t_in;
		logic [64:0] rs;
		logic [65:0] diff;
		for (int k = 0; k < QBITS; k++) begin
			if (k == 0) begin
				n_in = num_mag << FRAC_BITS;
				d_in = den_mag;
				r_in = '0;
				q_in = '0;
				t_in = in_tag;
			end else begin
				n_in = n_q[k-1];
				d_in = d_q[k-1];
				r_in = r_q[k-1];
				q_in = q_q[k-1];
				t_in = t_q[k-1];
			end
			rs   = {r_in, n_in[63]};
			diff = {1'b0, rs} - {2'b00, d_in};
			n_q[k] <= {n_in[62:0], 1'b0};
			d_q[k] <= d_in;
			t_q[k] <= t_in;
			if (!diff[65]) begin
				r_q[k] <= diff[63:0];
				q_q[k] <= {q_in[62:0], 1'b1};
			end else begin
				r_q[k] <= rs[63:0];
				q_q[k] <= {q_in[62:0], 1'b0};
			end
		end
	end

	// Quotients of 2^62 and above all saturate downstream; they are pinned to 2^62.
	assign out_valid = v_q[QBITS-1];
	assign quot      = (q_q[QBITS-1] >= (64'd1 << 62)) ? (64'd1 << 62) : q_q[QBITS-1];
	assign out_tag   = t_q[QBITS-1];
endmodule

/* src/vertex_matrix_transform.sv */
// Top level of the vertex matrix transform: register file, product and sum
// stages, the divider lanes and saturation. Depends on vmt_pkg, vmt_regs, vmt_div.
`timescale 1ns / 1ps
// Channel   | Signals                          | Transaction
// ----------+----------------------------------+-----------------------------
// point in  | start, busy, point               | start && !busy
// result    | done, result                     | done high for one cycle
// config    | psel penable pwrite paddr pwdata | psel && penable && pwrite
//
// One point enters every cycle; busy is never raised. The result passes through
// four arithmetic stages, the 64-stage quotient pipeline and the output register,
// the first of them clocked at the accepting edge. Reset clears only the stage
// control, valid bits and done, and loads the identity matrix into the register
// file. The result side cannot stall, so nothing holds the pipeline.
module vertex_matrix_transform #(
	parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = vmt_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  vmt_pkg::point_in_t            point,
	output logic                          done,
	output vmt_pkg::point_out_t           result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vmt_pkg::ADDR_BITS-1:0] paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready
);
	logic [63:0] regs [vmt_pkg::NUM_REGS];

	vmt_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .regs
	);

	assign pready = 1'b1;
	assign busy   = 1'b0;

	function automatic logic signed [32:0] ent(input logic [63:0] r, input logic hi);
		logic [31:0] h;
		h = hi ? r[63:32] : r[31:0];
		return 33'(signed'(h[WORD_BITS-1:0]));
	endfunction

	function automatic logic signed [32:0] sx(input logic [31:0] v);
		return 33'(signed'(v[WORD_BITS-1:0]));
	endfunction

	// Stage 1: operand selection (mode 2 subtraction included).
	vmt_pkg::stage_ctl_t      c_s1;
	logic signed [32:0]       p_s1 [3];
	logic signed [32:0]       m_s1 [3][3];
	logic signed [32:0]       t_s1 [3];
	logic signed [32:0]       mw_s1 [3];
	logic signed [32:0]       w0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_s1 <= '0;
		else         c_s1 <= '{valid: start, mode: point.mode};
	end

	always_ff @(posedge clk) begin
		logic signed [32:0] pp [3];
		logic signed [32:0] e [4][4];
		pp[0] = sx(point.in_x);
		pp[1] = sx(point.in_y);
		pp[2] = sx(point.in_z);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				e[r][c] = ent(regs[r*2 + c/2], c[0]);
		for (int j = 0; j < 3; j++) begin
			p_s1[j]  <= (point.mode == vmt_pkg::MODE_INV) ? pp[j] - e[3][j] : pp[j];
			t_s1[j]  <= e[3][j];
			mw_s1[j] <= e[j][3];
			for (int i = 0; i < 3; i++)
				m_s1[i][j] <= (point.mode[1]) ? e[i][j] : e[j][i];
		end
		w0_s1 <= e[3][3];
	end

	// Stage 2: twelve products, floored by FRAC_BITS (arithmetic shift floors).
	vmt_pkg::stage_ctl_t c_s2;
	vmt_pkg::wide_t      pr_s2 [3][3];
	vmt_pkg::wide_t      pw_s2 [3];
	logic signed [32:0]  t_s2 [3];
	logic signed [32:0]  w0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_s2 <= '0;
		else         c_s2 <= c_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++)
				pr_s2[i][j] <= (66'(p_s1[j]) * 66'(m_s1[i][j])) >>> FRAC_BITS;
			pw_s2[i] <= (66'(p_s1[i]) * 66'(mw_s1[i])) >>> FRAC_BITS;
			t_s2[i]  <= t_s1[i];
		end
		w0_s2 <= w0_s1;
	end

	// Stage 3: sums.
	vmt_pkg::stage_ctl_t c_s3;
	vmt_pkg::wide_t      s_s3 [3];
	vmt_pkg::wide_t      w_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_s3 <= '0;
		else         c_s3 <= c_s2;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			s_s3[i] <= pr_s2[i][0] + pr_s2[i][1] + pr_s2[i][2]
				+ ((c_s2.mode == vmt_pkg::MODE_FULL) ? 66'(t_s2[i]) : '0);
		w_s3 <= pw_s2[0] + pw_s2[1] + pw_s2[2] + 66'(w0_s2);
	end

	// Stage 4: magnitudes and signs for the divider.
	vmt_pkg::stage_ctl_t c_s4;
	logic [63:0]         nm_s4 [3];
	logic [63:0]         dm_s4;
	logic [2:0]          ng_s4;
	vmt_pkg::wide_t      s_s4 [3];
	logic                wz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_s4 <= '0;
		else         c_s4 <= c_s3;
	end

	always_ff @(posedge clk) begin
		vmt_pkg::wide_t a;
		vmt_pkg::wide_t d;
		d = w_s3[65] ? -w_s3 : w_s3;
		dm_s4 <= d[63:0];
		wz_s4 <= (w_s3 == '0);
		for (int i = 0; i < 3; i++) begin
			a = s_s3[i][65] ? -s_s3[i] : s_s3[i];
			nm_s4[i] <= a[63:0];
			ng_s4[i] <= s_s3[i][65] ^ w_s3[65];
			s_s4[i]  <= s_s3[i];
		end
	end

	// Divider lanes; the direct sums ride alongside in a matching delay line.
	localparam int DLAT = 64;
	logic        dv [3];
	logic [63:0] dq [3];
	logic [3:0]  dt [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		vmt_div #(.FRAC_BITS(FRAC_BITS), .QBITS(DLAT)) u_div (
			.clk, .arst_n,
			.in_valid (c_s4.valid),
			.num_mag  (nm_s4[i]),
			.den_mag  (wz_s4 ? 64'd1 : dm_s4),
			.in_tag   ({ng_s4[i], wz_s4, c_s4.mode}),
			.out_valid(dv[i]),
			.quot     (dq[i]),
			.out_tag  (dt[i])
		);
	end

	vmt_pkg::wide_t sd_q [DLAT][3];
	always_ff @(posedge clk) begin
		sd_q[0] <= s_s4;
		for (int k = 1; k < DLAT; k++)
			sd_q[k] <= sd_q[k-1];
	end

	// Final stage: select, saturate, flag.
	localparam logic signed [65:0] HI = 66'((64'sd1 <<< (WORD_BITS-1)) - 1);
	localparam logic signed [65:0] LO = -HI - 66'sd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= dv[0];
	end

	always_ff @(posedge clk) begin
		vmt_pkg::wide_t v;
		logic ov;
		logic signed [31:0] o [3];
		ov = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (dt[0][1:0] == vmt_pkg::MODE_FULL)
				v = dt[i][3] ? -66'(dq[i]) : 66'(dq[i]);
			else
				v = sd_q[DLAT-1][i];
			if (v > HI) begin
				v = HI; ov = 1'b1;
			end else if (v < LO) begin
				v = LO; ov = 1'b1;
			end
			o[i] = v[31:0];
		end
		if (dt[0][1:0] == vmt_pkg::MODE_FULL && dt[0][2]) begin
			result.out_x <= '0;
			result.out_y <= '0;
			result.out_z <= '0;
			result.divide_fault <= 1'b1;
			result.overflow <= 1'b0;
		end else begin
			result.out_x <= o[0];
			result.out_y <= o[1];
			result.out_z <= o[2];
			result.divide_fault <= 1'b0;
			result.overflow <= ov;
		end
	end
endmodule

/* sim/vertex_matrix_transform_tb.sv */
// Self-checking testbench for vertex_matrix_transform: directed table, then random
// points under several matrices, each result checked against its typed value or a
// behavioural predictor. Depends on vmt_pkg and the vertex_matrix_transform RTL.
`timescale 1ns / 1ps
module vertex_matrix_transform_tb;
	typedef logic signed [127:0] big_t;

	typedef enum int {
		ROW0_LO, ROW0_HI, ROW1_LO, ROW1_HI, ROW2_LO, ROW2_HI, ROW3_LO, ROW3_HI
	} mat_reg_e;

	typedef enum int {PH_IDENTITY, PH_ZERO_W, PH_EXTREME} dir_phase_e;

	typedef struct {
		dir_phase_e          phase;
		vmt_pkg::point_in_t  pt;
		bit                  typed;
		vmt_pkg::point_out_t want;
	} dir_row_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	vmt_pkg::point_in_t    point = '0;
	logic                  done;
	vmt_pkg::point_out_t   result;
	logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [vmt_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [63:0]           pwdata = '0, prdata;
	logic                  pready;

	logic [63:0]           mat_regs [8];
	vmt_pkg::point_out_t   pending_points [$];
	dir_row_t              dir_tab [$];
	int                    mismatches = 0;
	int                    cycles = 0;
	bit                    gaps_on = 1'b1;

	vertex_matrix_transform DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic big_t mat_entry(int r, int c);
		logic [63:0] rv;
		logic [31:0] half;
		rv = mat_regs[r * 2 + c / 2];
		half = (c % 2) ? rv[63:32] : rv[31:0];
		return big_t'($signed(half));
	endfunction

	// Exact product, floored back to the fixed-point scale.
	function automatic big_t fx_mul(big_t a, big_t b);
		big_t p;
		p = a * b;
		return p >>> 16;
	endfunction

	// Quotient truncated toward zero; huge quotients are pinned so they saturate.
	function automatic big_t fx_div(big_t num, big_t den);
		big_t n, d, q;
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		if (n / d >= (big_t'(1) <<< 46))
			q = big_t'(1) <<< 62;
		else
			q = (n <<< 16) / d;
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic logic [31:0] clamp32(big_t v, inout logic ovf);
		if (v > big_t'(S_MAX)) begin
			ovf = 1'b1;
			return S_MAX;
		end
		if (v < big_t'(S_MIN)) begin
			ovf = 1'b1;
			return S_MIN;
		end
		return v[31:0];
	endfunction

	function automatic vmt_pkg::point_out_t transform_point(vmt_pkg::point_in_t pt);
		big_t p [3];
		big_t s [3];
		big_t w;
		logic ovf;
		vmt_pkg::point_out_t r;
		ovf = 1'b0;
		r = '0;
		p[0] = big_t'(pt.in_x);
		p[1] = big_t'(pt.in_y);
		p[2] = big_t'(pt.in_z);
		if (pt.mode == vmt_pkg::MODE_INV)
			for (int j = 0; j < 3; j++)
				p[j] = p[j] - mat_entry(3, j);
		for (int i = 0; i < 3; i++) begin
			s[i] = (pt.mode == vmt_pkg::MODE_FULL) ? mat_entry(3, i) : big_t'(0);
			for (int j = 0; j < 3; j++)
				s[i] = s[i] + fx_mul(p[j],
					(pt.mode == vmt_pkg::MODE_INV || pt.mode == vmt_pkg::MODE_INV_ROT)
					? mat_entry(i, j) : mat_entry(j, i));
		end
		if (pt.mode == vmt_pkg::MODE_FULL) begin
			w = mat_entry(3, 3);
			for (int j = 0; j < 3; j++)
				w = w + fx_mul(p[j], mat_entry(j, 3));
			if (w == 0) begin
				r.divide_fault = 1'b1;
				return r;
			end
			for (int i = 0; i < 3; i++)
				s[i] = fx_div(s[i], w);
		end
		r.out_x = clamp32(s[0], ovf);
		r.out_y = clamp32(s[1], ovf);
		r.out_z = clamp32(s[2], ovf);
		r.overflow = ovf;
		return r;
	endfunction

	always @(posedge clk) begin
		vmt_pkg::point_out_t want;
		if (arst_n && done) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transaction: %p", result);
			end else begin
				want = pending_points.pop_front();
				if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
				    result.out_z !== want.out_z || result.divide_fault !== want.divide_fault ||
				    result.overflow !== want.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: expected %p, got %p", want, result);
				end
			end
		end
	end

	task automatic write_matrix_reg(mat_reg_e idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= vmt_pkg::ADDR_BITS'(idx * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mat_regs[idx] = value;
	endtask

	task automatic drain_points();
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_matrix(logic [63:0] vals [8]);
		drain_points();
		for (int i = 0; i < 8; i++)
			write_matrix_reg(mat_reg_e'(i), vals[i]);
	endtask

	task automatic issue_point(vmt_pkg::point_in_t pt, bit typed, vmt_pkg::point_out_t want);
		point <= pt;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_points.push_back(typed ? want : transform_point(pt));
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_coord();
		unique case ($urandom_range(0, 5))
			0: return S_MAX;
			1: return S_MIN;
			2: return $urandom();
			default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
		endcase
	endfunction

	function automatic logic [31:0] rand_entry();
		unique case ($urandom_range(0, 7))
			0: return '0;
			1: return $urandom();
			2: return S_MAX;
			3: return S_MIN;
			default: return 32'($signed($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	function automatic void add_row(dir_phase_e ph, logic [1:0] m, logic [31:0] x,
	                                logic [31:0] y, logic [31:0] z, bit typed,
	                                vmt_pkg::point_out_t want);
		dir_row_t row;
		row.phase = ph;
		row.pt = '{mode: m, in_x: x, in_y: y, in_z: z};
		row.typed = typed;
		row.want = want;
		dir_tab.push_back(row);
	endfunction

	function automatic vmt_pkg::point_out_t same_point(logic [31:0] x, logic [31:0] y,
	                                                   logic [31:0] z);
		return '{out_x: x, out_y: y, out_z: z, divide_fault: 1'b0, overflow: 1'b0};
	endfunction

	initial begin
		logic [63:0] vals [8];
		vmt_pkg::point_in_t pt;
		vmt_pkg::point_out_t fault_out;
		dir_phase_e cur_phase;

		fault_out = '{out_x: '0, out_y: '0, out_z: '0, divide_fault: 1'b1, overflow: 1'b0};
		mat_regs = '{vmt_pkg::RESET_LOW, 64'd0, vmt_pkg::RESET_HIGH, 64'd0, 64'd0,
			vmt_pkg::RESET_LOW, 64'd0, vmt_pkg::RESET_HIGH};

		// Identity matrix after reset passes every point straight through.
		for (int m = 0; m < 4; m++) begin
			add_row(PH_IDENTITY, 2'(m), S_MAX, S_MIN, 32'd0, 1'b1,
				same_point(S_MAX, S_MIN, 32'd0));
			add_row(PH_IDENTITY, 2'(m), 32'hFFFF_FFFF, 32'h0001_0000, S_MAX, 1'b1,
				same_point(32'hFFFF_FFFF, 32'h0001_0000, S_MAX));
		end
		// No w column: every full transform divides by zero.
		add_row(PH_ZERO_W, vmt_pkg::MODE_FULL, 32'h0001_0000, 32'd5, S_MIN, 1'b1, fault_out);
		add_row(PH_ZERO_W, vmt_pkg::MODE_FULL, 32'd0, 32'd0, 32'd0, 1'b1, fault_out);
		add_row(PH_ZERO_W, vmt_pkg::MODE_FULL, S_MAX, S_MAX, S_MAX, 1'b1, fault_out);
		// Extreme entries drive saturation in both directions.
		for (int m = 0; m < 4; m++) begin
			add_row(PH_EXTREME, 2'(m), S_MAX, S_MAX, S_MAX, 1'b0, '0);
			add_row(PH_EXTREME, 2'(m), S_MIN, S_MIN, S_MIN, 1'b0, '0);
			add_row(PH_EXTREME, 2'(m), S_MIN, S_MAX, 32'h0000_8000, 1'b0, '0);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		cur_phase = PH_IDENTITY;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].phase != cur_phase) begin
				cur_phase = dir_tab[i].phase;
				start <= 1'b0;
				if (cur_phase == PH_ZERO_W)
					vals = '{vmt_pkg::RESET_LOW, 64'd0, vmt_pkg::RESET_HIGH, 64'd0, 64'd0,
						vmt_pkg::RESET_LOW, 64'h0000_0003_0002_0001, 64'd0};
				else
					vals = '{{S_MIN, S_MAX}, {S_MAX, S_MIN}, {S_MAX, S_MAX}, {S_MIN, S_MIN},
						64'hFFFF_FFFF_FFFF_FFFF, {S_MAX, 32'd1}, {S_MIN, S_MAX},
						{32'h0000_0001, S_MIN}};
				load_matrix(vals);
			end
			issue_point(dir_tab[i].pt, dir_tab[i].typed, dir_tab[i].want);
		end

		for (int blk = 0; blk < 8; blk++) begin
			start <= 1'b0;
			for (int i = 0; i < 8; i++)
				vals[i] = {rand_entry(), rand_entry()};
			// Clear the w column now and then so that divide faults turn up.
			if (blk == 3 || blk == 5) begin
				vals[ROW0_HI][63:32] = '0;
				vals[ROW1_HI][63:32] = '0;
				vals[ROW2_HI][63:32] = '0;
				vals[ROW3_HI][63:32] = '0;
			end
			load_matrix(vals);
			gaps_on = (blk < 6);
			for (int n = 0; n < 50; n++) begin
				pt.mode = 2'($urandom_range(0, 3));
				pt.in_x = rand_coord();
				pt.in_y = rand_coord();
				pt.in_z = rand_coord();
				issue_point(pt, 1'b0, '0);
			end
		end
		start <= 1'b0;

		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
